// ===== rtl/tilt_pi_stabilizer_macros.svh =====
// Assertion macros shared by the tilt PI stabiliser RTL.
// Included by the controller and datapath modules; no other dependencies.
`ifndef TILT_PI_STABILIZER_MACROS_SVH
`define TILT_PI_STABILIZER_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define TPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tps_pkg.sv =====
// Package for the tilt PI stabiliser: widths, constants, register codes,
// command and status types, and the CORDIC arctangent table. No dependencies.
`default_nettype none

package tps_pkg;

    // Defaults and fixed widths
    localparam int CORDIC_STEPS_DEFAULT = 16;
    localparam int ATAN_TABLE_LEN       = 24;
    localparam int ATAN_IDX_W           = $clog2(ATAN_TABLE_LEN);
    localparam int SAMPLE_W             = 16;
    localparam int CORDIC_W             = 36;
    localparam int ANGLE_W              = 34;
    localparam int DIFF_W               = 17;
    localparam int INTEG_W              = 48;
    localparam int MUL_A_W              = 25;
    localparam int MUL_B_W              = 17;
    localparam int PROD_W               = MUL_A_W + MUL_B_W;
    localparam int SUM_W                = 58;
    localparam int CFG_IDX_W            = 4;
    localparam int CFG_DATA_W           = 16;

    // Angle constants, 2^30 per radian inside the CORDIC, Q2.13 outside
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30  = 34'sd1686629713;
    localparam logic signed [ANGLE_W-1:0] ROUND_BIAS   = 34'sd65536;
    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT  = 34'sd25736;
    localparam logic [SAMPLE_W-1:0]       OPEN_LIMIT   = 16'd20016;
    localparam logic [DIFF_W-1:0]         SETTLE_LIMIT = 17'd573;
    localparam logic [SAMPLE_W-1:0]       FULL_SCALE   = 16'h8000;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] TARGET_ANGLE_RESET   = 16'd0;
    localparam logic [CFG_DATA_W-1:0] PROP_GAIN_RESET      = 16'd256;
    localparam logic [CFG_DATA_W-1:0] INTEG_GAIN_RESET     = 16'd0;
    localparam logic [CFG_DATA_W-1:0] PERIOD_SECONDS_RESET = 16'd655;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SECONDS = 4'd3;

    // Operand selection for the shared multiplier
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_PERIOD,
        MUL_PROP,
        MUL_LO,
        MUL_HI
    } mul_sel_t;

    // Update of the PI sum accumulator
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_HI
    } acc_op_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                  load;
        logic                  iterate;
        logic [ATAN_IDX_W-1:0] step;
        logic                  round;
        logic                  diff;
        mul_sel_t              mul_sel;
        logic                  integ;
        acc_op_t               acc_op;
        logic                  publish;
    } tps_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_busy;
    } tps_status_t;

    // atan(2^-i) with 2^30 per radian
    function automatic logic [29:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [29:0] val;
        begin
            unique case (idx)
                5'd0:    val = 30'h3243F6A8;
                5'd1:    val = 30'h1DAC6705;
                5'd2:    val = 30'h0FADBAFC;
                5'd3:    val = 30'h07F56EA6;
                5'd4:    val = 30'h03FEAB76;
                5'd5:    val = 30'h01FFD55B;
                5'd6:    val = 30'h00FFFAAA;
                5'd7:    val = 30'h007FFF55;
                5'd8:    val = 30'h003FFFEA;
                5'd9:    val = 30'h001FFFFD;
                5'd10:   val = 30'h000FFFFF;
                5'd11:   val = 30'h0007FFFF;
                5'd12:   val = 30'h0003FFFF;
                5'd13:   val = 30'h0001FFFF;
                5'd14:   val = 30'h0000FFFF;
                5'd15:   val = 30'h00007FFF;
                5'd16:   val = 30'h00003FFF;
                5'd17:   val = 30'h00001FFF;
                5'd18:   val = 30'h00000FFF;
                5'd19:   val = 30'h000007FF;
                5'd20:   val = 30'h000003FF;
                5'd21:   val = 30'h000001FF;
                5'd22:   val = 30'h000000FF;
                5'd23:   val = 30'h0000007F;
                default: val = 30'h00000000;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tps_sample_if.sv =====
// Sample channel of the tilt PI stabiliser: valid/ready plus Y and Z axes.
// Depends on tps_pkg for the sample width.
`default_nettype none

interface tps_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tps_pkg::SAMPLE_W-1:0]  accel_y;
    logic signed [tps_pkg::SAMPLE_W-1:0]  accel_z;

    modport source (output valid, output accel_y, output accel_z, input ready);
    modport sink   (input valid, input accel_y, input accel_z, output ready);
endinterface

`default_nettype wire

// ===== rtl/tps_result_if.sv =====
// Result channel of the tilt PI stabiliser: valid/ready plus drive and flags.
// Depends on tps_pkg for the field widths.
`default_nettype none

interface tps_result_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 drive_reverse;
    logic        [tps_pkg::SAMPLE_W-1:0]  drive_magnitude;
    logic signed [tps_pkg::SAMPLE_W-1:0]  tilt_angle;
    logic                                 settled;
    logic                                 beyond_open_limit;

    modport source (
        output valid, output drive_reverse, output drive_magnitude,
        output tilt_angle, output settled, output beyond_open_limit,
        input  ready
    );
    modport sink (
        input  valid, input drive_reverse, input drive_magnitude,
        input  tilt_angle, input settled, input beyond_open_limit,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/tps_cfg_if.sv =====
// Configuration write channel of the tilt PI stabiliser: valid/ready,
// register index and write data. Depends on tps_pkg for the widths.
`default_nettype none

interface tps_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tps_pkg::CFG_IDX_W-1:0]     index;
    logic [tps_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tps_ctrl.sv =====
// Controller of the tilt PI stabiliser: sequences the CORDIC iterations and
// the PI arithmetic. Depends on tps_pkg, tps_sample_if and the macro header.
`default_nettype none
`include "tilt_pi_stabilizer_macros.svh"

module tps_ctrl #(
    parameter int CORDIC_STEPS = tps_pkg::CORDIC_STEPS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    tps_sample_if.sink                sample,
    input  wire tps_pkg::tps_status_t status,
    output tps_pkg::tps_cmd_t         cmd
);

    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int IDX_W  = tps_pkg::ATAN_IDX_W;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORDIC,
        S_ROUND,
        S_DIFF,
        S_MPER,
        S_INTEG,
        S_MLO,
        S_MHI,
        S_ACC,
        S_DONE
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [STEP_W-1:0]  step_cnt_reg;
    logic [STEP_W-1:0]  step_cnt_next;

    // A new request is taken only between items.
    assign sample.ready = (state_reg == S_IDLE);

    // Next state, step count and commands for the datapath.
    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        cmd.mul_sel   = tps_pkg::MUL_NONE;
        cmd.acc_op    = tps_pkg::ACC_HOLD;
        cmd.step      = IDX_W'(step_cnt_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    cmd.load      = 1'b1;
                    step_cnt_next = '0;
                    state_next    = S_CORDIC;
                end
            end
            S_CORDIC:
            begin
                cmd.iterate = 1'b1;
                if (step_cnt_reg == LAST_STEP)
                begin
                    state_next = S_ROUND;
                end
                else
                begin
                    step_cnt_next = step_cnt_reg + 1'b1;
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_MPER;
            end
            S_MPER:
            begin
                cmd.mul_sel = tps_pkg::MUL_PERIOD;
                state_next  = S_INTEG;
            end
            S_INTEG:
            begin
                cmd.integ   = 1'b1;
                cmd.mul_sel = tps_pkg::MUL_PROP;
                state_next  = S_MLO;
            end
            S_MLO:
            begin
                cmd.acc_op  = tps_pkg::ACC_LOAD;
                cmd.mul_sel = tps_pkg::MUL_LO;
                state_next  = S_MHI;
            end
            S_MHI:
            begin
                cmd.acc_op  = tps_pkg::ACC_ADD;
                cmd.mul_sel = tps_pkg::MUL_HI;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_op = tps_pkg::ACC_ADD_HI;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    // An accepted request starts the CORDIC at its first step.
    `TPS_ASSERT(a_start_cordic, clk, rst_n, (sample.valid && sample.ready) |=> (state_reg == S_CORDIC && step_cnt_reg == '0), "CORDIC did not start at step zero")
    // The last CORDIC step hands over to rounding.
    `TPS_ASSERT(a_cordic_end, clk, rst_n, (state_reg == S_CORDIC && step_cnt_reg == LAST_STEP) |=> (state_reg == S_ROUND), "CORDIC ran past its last step")
    // Publishing a result frees the block for the next request.
    `TPS_ASSERT(a_publish_idle, clk, rst_n, cmd.publish |=> sample.ready, "block not ready after publishing")

endmodule

`default_nettype wire

// ===== rtl/tps_datapath.sv =====
// Datapath of the tilt PI stabiliser: configuration registers, CORDIC
// vectoring unit, shared multiplier, integrator, PI sum and output register.
// Depends on tps_pkg, the channel interfaces and the macro header.
`default_nettype none
`include "tilt_pi_stabilizer_macros.svh"

module tps_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    tps_sample_if.sink                sample,
    tps_result_if.source              result,
    tps_cfg_if.sink                   cfg,
    input  wire tps_pkg::tps_cmd_t    cmd,
    output tps_pkg::tps_status_t      status
);

    localparam int CW = tps_pkg::CORDIC_W;
    localparam int AW = tps_pkg::ANGLE_W;
    localparam int DW = tps_pkg::DIFF_W;
    localparam int IW = tps_pkg::INTEG_W;
    localparam int PW = tps_pkg::PROD_W;
    localparam int SW = tps_pkg::SUM_W;
    localparam int XW = tps_pkg::SAMPLE_W;

    // Configuration registers
    logic signed [XW-1:0] target_reg;
    logic [XW-1:0]        prop_gain_reg;
    logic [XW-1:0]        integ_gain_reg;
    logic [XW-1:0]        period_reg;

    // CORDIC state
    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] v_reg, v_next;
    logic signed [AW-1:0] ang_reg, ang_next;
    logic signed [CW-1:0] y_scaled, z_scaled, x_raw;
    logic signed [CW-1:0] dx, dv;
    logic signed [AW-1:0] atan_ext;

    // Angle, error and flags
    logic signed [AW-1:0] ang_biased, ang_shifted;
    logic signed [XW-1:0] tilt_reg, tilt_next;
    logic signed [DW-1:0] diff_reg, diff_next;
    logic [DW-1:0]        abs_diff;
    logic [XW-1:0]        abs_tilt;
    logic                 settled_flag_reg;
    logic                 beyond_reg;

    // Multiplier, integrator and PI sum
    logic signed [tps_pkg::MUL_A_W-1:0] mul_a;
    logic signed [tps_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]               prod_reg;
    logic signed [IW-1:0]               integ_reg, integ_next;
    logic signed [IW:0]                 integ_sum;
    logic signed [SW-1:0]               sum_reg, sum_next, prod_ext;
    logic [SW-1:0]                      abs_sum;
    logic [SW-7:0]                      mag_wide;
    logic [XW-1:0]                      mag_sat;

    // Output register
    logic                 out_valid_reg;
    logic                 out_reverse_reg;
    logic [XW-1:0]        out_mag_reg;
    logic signed [XW-1:0] out_tilt_reg;
    logic                 out_settled_reg;
    logic                 out_beyond_reg;

    // Configuration writes are always accepted.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= tps_pkg::TARGET_ANGLE_RESET;
            prop_gain_reg  <= tps_pkg::PROP_GAIN_RESET;
            integ_gain_reg <= tps_pkg::INTEG_GAIN_RESET;
            period_reg     <= tps_pkg::PERIOD_SECONDS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                tps_pkg::REG_TARGET_ANGLE:   target_reg     <= cfg.data;
                tps_pkg::REG_PROP_GAIN:      prop_gain_reg  <= cfg.data;
                tps_pkg::REG_INTEG_GAIN:     integ_gain_reg <= cfg.data;
                tps_pkg::REG_PERIOD_SECONDS: period_reg     <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // Quarter-turn pre-rotation on load when x is negative, then one vectoring step per cycle.
    always_comb
    begin
        y_scaled = {{(CW-32){sample.accel_y[XW-1]}}, sample.accel_y, 16'h0000};
        z_scaled = {{(CW-32){sample.accel_z[XW-1]}}, sample.accel_z, 16'h0000};
        x_raw    = -y_scaled;
        dx       = v_reg >>> cmd.step;
        dv       = x_reg >>> cmd.step;
        atan_ext = {{(AW-30){1'b0}}, tps_pkg::atan_q30(cmd.step)};
        x_next   = x_reg;
        v_next   = v_reg;
        ang_next = ang_reg;
        if (cmd.load)
        begin
            if (x_raw < 0)
            begin
                if (z_scaled >= 0)
                begin
                    x_next   = z_scaled;
                    v_next   = -x_raw;
                    ang_next = tps_pkg::HALF_PI_Q30;
                end
                else
                begin
                    x_next   = -z_scaled;
                    v_next   = x_raw;
                    ang_next = -tps_pkg::HALF_PI_Q30;
                end
            end
            else
            begin
                x_next   = x_raw;
                v_next   = z_scaled;
                ang_next = '0;
            end
        end
        else if (cmd.iterate)
        begin
            if (v_reg > 0)
            begin
                x_next   = x_reg + dx;
                v_next   = v_reg - dv;
                ang_next = ang_reg + atan_ext;
            end
            else if (v_reg < 0)
            begin
                x_next   = x_reg - dx;
                v_next   = v_reg + dv;
                ang_next = ang_reg - atan_ext;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        v_reg   <= v_next;
        ang_reg <= ang_next;
    end

    // Round the angle to Q2.13 half up and clamp it to plus or minus pi.
    always_comb
    begin
        ang_biased  = ang_reg + tps_pkg::ROUND_BIAS;
        ang_shifted = ang_biased >>> 17;
        if (ang_shifted > tps_pkg::ANGLE_LIMIT)
        begin
            tilt_next = XW'(tps_pkg::ANGLE_LIMIT);
        end
        else if (ang_shifted < -tps_pkg::ANGLE_LIMIT)
        begin
            tilt_next = XW'(-tps_pkg::ANGLE_LIMIT);
        end
        else
        begin
            tilt_next = ang_shifted[XW-1:0];
        end
    end

    // Error against the target and its magnitude, plus the tilt magnitude.
    always_comb
    begin
        diff_next = {tilt_reg[XW-1], tilt_reg} - {target_reg[XW-1], target_reg};
        abs_diff  = diff_next[DW-1] ? DW'(-diff_next) : DW'(diff_next);
        abs_tilt  = tilt_reg[XW-1] ? XW'(-tilt_reg) : XW'(tilt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.round)
        begin
            tilt_reg <= tilt_next;
        end
        if (cmd.diff)
        begin
            diff_reg   <= diff_next;
            beyond_reg <= (abs_tilt > tps_pkg::OPEN_LIMIT);
        end
    end

    // Sticky settle flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settled_flag_reg <= 1'b0;
        end
        else if (cmd.diff && (abs_diff <= tps_pkg::SETTLE_LIMIT))
        begin
            settled_flag_reg <= 1'b1;
        end
    end

    // Shared multiplier operand selection; the integral is taken apart into
    // a signed upper part and an unsigned lower part after the shift by 8.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            tps_pkg::MUL_PERIOD:
            begin
                mul_a = {{(tps_pkg::MUL_A_W-DW){diff_reg[DW-1]}}, diff_reg};
                mul_b = {1'b0, period_reg};
            end
            tps_pkg::MUL_PROP:
            begin
                mul_a = {{(tps_pkg::MUL_A_W-DW){diff_reg[DW-1]}}, diff_reg};
                mul_b = {1'b0, prop_gain_reg};
            end
            tps_pkg::MUL_LO:
            begin
                mul_a = {{(tps_pkg::MUL_A_W-16){1'b0}}, integ_reg[23:8]};
                mul_b = {1'b0, integ_gain_reg};
            end
            tps_pkg::MUL_HI:
            begin
                mul_a = {{(tps_pkg::MUL_A_W-24){integ_reg[IW-1]}}, integ_reg[IW-1:24]};
                mul_b = {1'b0, integ_gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_sel != tps_pkg::MUL_NONE)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // Saturating integrator of error times period.
    always_comb
    begin
        integ_sum = {integ_reg[IW-1], integ_reg} + {{(IW+1-PW){prod_reg[PW-1]}}, prod_reg};
        if (integ_sum[IW] != integ_sum[IW-1])
        begin
            integ_next = integ_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        end
        else
        begin
            integ_next = integ_sum[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else if (cmd.integ)
        begin
            integ_reg <= integ_next;
        end
    end

    // PI sum accumulator.
    always_comb
    begin
        prod_ext = {{(SW-PW){prod_reg[PW-1]}}, prod_reg};
        sum_next = sum_reg;
        unique case (cmd.acc_op)
            tps_pkg::ACC_LOAD:   sum_next = prod_ext;
            tps_pkg::ACC_ADD:    sum_next = sum_reg + prod_ext;
            tps_pkg::ACC_ADD_HI: sum_next = sum_reg + (prod_ext <<< 16);
            default:             sum_next = sum_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    // Drive magnitude: absolute sum over 2^6, saturated at full scale.
    always_comb
    begin
        abs_sum  = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
        mag_wide = abs_sum[SW-1:6];
        if (mag_wide > {{(SW-6-XW){1'b0}}, tps_pkg::FULL_SCALE})
        begin
            mag_sat = tps_pkg::FULL_SCALE;
        end
        else
        begin
            mag_sat = mag_wide[XW-1:0];
        end
    end

    // Output register, parting the result side from the arithmetic.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_reverse_reg <= !sum_reg[SW-1] && (sum_reg != '0);
            out_mag_reg     <= mag_sat;
            out_tilt_reg    <= tilt_reg;
            out_settled_reg <= settled_flag_reg;
            out_beyond_reg  <= beyond_reg;
        end
    end

    assign status.out_busy          = out_valid_reg && !result.ready;
    assign result.valid             = out_valid_reg;
    assign result.drive_reverse     = out_reverse_reg;
    assign result.drive_magnitude   = out_mag_reg;
    assign result.tilt_angle        = out_tilt_reg;
    assign result.settled           = out_settled_reg;
    assign result.beyond_open_limit = out_beyond_reg;

    // The settle flag never clears once set.
    `TPS_ASSERT(a_settled_sticky, clk, rst_n, settled_flag_reg |=> settled_flag_reg, "settle flag cleared")
    // A rounded tilt stays within plus or minus pi.
    `TPS_ASSERT(a_tilt_range, clk, rst_n, cmd.round |=> ((tilt_reg <= 16'sd25736) && (tilt_reg >= -16'sd25736)), "tilt out of range")
    // A shown drive level never exceeds full scale.
    `TPS_ASSERT_ALWAYS(a_mag_limit, clk, result.valid |-> (result.drive_magnitude <= tps_pkg::FULL_SCALE), "drive magnitude above full scale")
    // A result is published only into a free output register.
    `TPS_ASSERT(a_publish_free, clk, rst_n, cmd.publish |-> (!out_valid_reg || result.ready), "result overwritten before it was taken")

endmodule

`default_nettype wire

// ===== rtl/tilt_pi_stabilizer.sv =====
// Top level of the tilt PI stabiliser: joins controller and datapath.
// Depends on tps_pkg, the channel interfaces, tps_ctrl and tps_datapath.
//
//   Channel  Direction  Payload
//   sample   in         accel_y, accel_z
//   result   out        drive_reverse, drive_magnitude, tilt_angle, settled,
//                       beyond_open_limit
//   cfg      in         index, data (register write, always ready)
//
// A request runs CORDIC_STEPS loop steps (16 by default), one step per cycle,
// then the PI arithmetic on the single shared multiplier, before the next
// one can be accepted.
// The result waits in an output register; a stalled result holds the block
// only when the next result is ready to be written over it.
// Reset clears the integrator, the settle flag and the configuration
// registers to their defaults; no clearing pass is needed.
`default_nettype none

module tilt_pi_stabilizer #(
    parameter int CORDIC_STEPS = tps_pkg::CORDIC_STEPS_DEFAULT
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tps_sample_if.sink   sample,
    tps_result_if.source result,
    tps_cfg_if.sink      cfg
);

    tps_pkg::tps_cmd_t    cmd;
    tps_pkg::tps_status_t status;

    // Sequencer
    tps_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .status (status),
        .cmd    (cmd)
    );

    // Arithmetic and storage
    tps_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .result (result),
        .cfg    (cfg),
        .cmd    (cmd),
        .status (status)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for the tilt PI stabiliser: drives sample requests and register
// writes, predicts every result with a CORDIC and PI model and compares them.
// Depends on tps_pkg, the three channel interfaces and tilt_pi_stabilizer.
module tb;

    localparam int SAMPLE_W = tps_pkg::SAMPLE_W;
    localparam int CFG_IDX_W = tps_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = tps_pkg::CFG_DATA_W;
    localparam int STEPS = 16;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint INTEGRAL_MAX = 64'sd140737488355327;
    localparam longint INTEGRAL_MIN = -INTEGRAL_MAX - 1;
    localparam longint TILT_LIMIT = 25736;
    localparam longint OPEN_TILT = 20016;
    localparam longint SETTLE_BAND = 573;
    localparam longint DRIVE_FULL = 32768;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 2 * STEPS + 20;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_SPARE = tps_pkg::REG_PERIOD_SECONDS + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_SPARE = {CFG_IDX_W{1'b1}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
    } sample_t;

    typedef struct packed {
        logic                       reverse;
        logic [SAMPLE_W-1:0]        magnitude;
        logic signed [SAMPLE_W-1:0] tilt;
        logic                       settled;
        logic                       beyond;
    } drive_result_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_BURSTY
    } rx_style_t;

    logic clk;
    logic rst_n;

    tps_sample_if sample_ch();
    tps_result_if result_ch();
    tps_cfg_if    cfg_ch();

    tilt_pi_stabilizer #(.CORDIC_STEPS(STEPS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Arctangent of 2^-i, 2^30 per radian.
    longint atan_steps [0:23] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    // Mirror of the block's configuration registers, integrator and settle flag.
    longint target_set;
    longint prop_set;
    longint integ_set;
    longint period_set;
    longint error_sum;
    logic   settled_seen;

    sample_t       sample_q [$];
    drive_result_t expected_drive_q [$];
    int            mismatches;

    int        burst_left;
    int        gap_left;
    rx_style_t rx_style;
    int        rx_window;
    int        rx_phase;
    int        hold_cnt;
    logic      hold_req;

    // Clock with a period of 10 time units.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Tilt angle atan2(z, -y) in Q2.13 by vectoring CORDIC.
    function automatic longint cordic_tilt(input logic signed [SAMPLE_W-1:0] ay,
                                           input logic signed [SAMPLE_W-1:0] az);
        longint x;
        longint v;
        longint ang;
        longint t;
        longint dx;
        longint dv;
        longint r;
        int     i;
        x = -longint'(ay) * 65536;
        v = longint'(az) * 65536;
        ang = 0;
        // Swing the vector into the right half plane first.
        if (x < 0)
        begin
            if (v >= 0)
            begin
                t = x;
                x = v;
                v = -t;
                ang = HALF_PI_Q30;
            end
            else
            begin
                t = x;
                x = -v;
                v = t;
                ang = -HALF_PI_Q30;
            end
        end
        for (i = 0; i < STEPS; i++)
        begin
            dx = v >>> i;
            dv = x >>> i;
            if (v > 0)
            begin
                x = x + dx;
                v = v - dv;
                ang = ang + atan_steps[i];
            end
            else if (v < 0)
            begin
                x = x - dx;
                v = v + dv;
                ang = ang - atan_steps[i];
            end
        end
        r = (ang + 65536) >>> 17;
        if (r > TILT_LIMIT)
            r = TILT_LIMIT;
        if (r < -TILT_LIMIT)
            r = -TILT_LIMIT;
        return r;
    endfunction

    // One control period: integrate the error and form the PI drive.
    function automatic drive_result_t predict_drive(input sample_t s);
        drive_result_t res;
        longint        tilt;
        longint        diff;
        longint        pi_sum;
        longint        mag;
        tilt = cordic_tilt(s.accel_y, s.accel_z);
        diff = tilt - target_set;
        error_sum = error_sum + diff * period_set;
        if (error_sum > INTEGRAL_MAX)
            error_sum = INTEGRAL_MAX;
        if (error_sum < INTEGRAL_MIN)
            error_sum = INTEGRAL_MIN;
        pi_sum = diff * prop_set + (error_sum >>> 8) * integ_set;
        mag = (pi_sum < 0 ? -pi_sum : pi_sum) >>> 6;
        if (mag > DRIVE_FULL)
            mag = DRIVE_FULL;
        if ((diff < 0 ? -diff : diff) <= SETTLE_BAND)
            settled_seen = 1'b1;
        res.reverse = pi_sum > 0;
        res.magnitude = mag[SAMPLE_W-1:0];
        res.tilt = tilt[SAMPLE_W-1:0];
        res.settled = settled_seen;
        res.beyond = (tilt < 0 ? -tilt : tilt) > OPEN_TILT;
        return res;
    endfunction

    // Random sample: full range, near the origin, near the axes or on an extreme.
    function automatic sample_t random_sample();
        sample_t s;
        int      a;
        int      b;
        s.accel_y = SAMPLE_W'($urandom());
        s.accel_z = SAMPLE_W'($urandom());
        case ($urandom_range(0, 5))
            0:
            begin
                a = int'($urandom_range(0, 600)) - 300;
                b = int'($urandom_range(0, 600)) - 300;
                s.accel_y = a[SAMPLE_W-1:0];
                s.accel_z = b[SAMPLE_W-1:0];
            end
            1:
            begin
                a = int'($urandom_range(0, 4000)) - 2000;
                s.accel_z = a[SAMPLE_W-1:0];
            end
            2:
            begin
                case ($urandom_range(0, 2))
                    0: s.accel_y = 16'sh8000;
                    1: s.accel_y = 16'sh7FFF;
                    default: s.accel_y = '0;
                endcase
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic queue_random(input int count);
        repeat (count)
            sample_q.push_back(random_sample());
    endtask

    task automatic queue_sample(input int ay, input int az);
        sample_t s;
        s.accel_y = ay[SAMPLE_W-1:0];
        s.accel_z = az[SAMPLE_W-1:0];
        sample_q.push_back(s);
    endtask

    // One register write request, held until the block takes it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] target,
                             input logic [CFG_DATA_W-1:0] prop,
                             input logic [CFG_DATA_W-1:0] integ,
                             input logic [CFG_DATA_W-1:0] period);
        write_reg(tps_pkg::REG_TARGET_ANGLE, target);
        write_reg(tps_pkg::REG_PROP_GAIN, prop);
        write_reg(tps_pkg::REG_INTEG_GAIN, integ);
        write_reg(tps_pkg::REG_PERIOD_SECONDS, period);
    endtask

    // Idle once nothing is queued, offered or outstanding.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (sample_q.size() != 0 || sample_ch.valid || expected_drive_q.size() != 0);
    endtask

    task automatic check_field(input string what, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    // Sample driver: bursts of requests separated by random gaps.
    always @(posedge clk)
    begin
        sample_t item;
        if (!rst_n)
            sample_ch.valid <= 1'b0;
        else if (!sample_ch.valid || sample_ch.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                sample_ch.valid <= 1'b0;
            end
            else if (sample_q.size() > 0)
            begin
                item = sample_q.pop_front();
                sample_ch.valid <= 1'b1;
                sample_ch.accel_y <= item.accel_y;
                sample_ch.accel_z <= item.accel_z;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                           : $urandom_range(0, 2);
                end
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    // Long hold-off of the result channel, requested by the stimulus.
    always @(posedge clk)
    begin
        if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (hold_req)
        begin
            hold_cnt <= HOLD_CYCLES;
            hold_req <= 1'b0;
        end
    end

    // Result receiver: stall style changes over windows of random length.
    always @(posedge clk)
    begin
        logic go;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (rx_window == 0)
            begin
                rx_style = rx_style_t'($urandom_range(0, 3));
                rx_window = $urandom_range(16, 96);
            end
            else
                rx_window--;
            rx_phase++;
            case (rx_style)
                RX_FREE:   go = 1'b1;
                RX_COIN:   go = 1'($urandom_range(0, 1));
                RX_SPARSE: go = (rx_phase % 4) == 0;
                default:   go = (rx_phase % 16) < 12;
            endcase
            result_ch.ready <= go && (hold_cnt == 0);
        end
    end

    // Register writes update the mirror; accepted samples yield expectations.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    tps_pkg::REG_TARGET_ANGLE:
                        target_set = longint'($signed(cfg_ch.data));
                    tps_pkg::REG_PROP_GAIN:      prop_set = longint'(cfg_ch.data);
                    tps_pkg::REG_INTEG_GAIN:     integ_set = longint'(cfg_ch.data);
                    tps_pkg::REG_PERIOD_SECONDS: period_set = longint'(cfg_ch.data);
                    default: ;
                endcase
            end
            if (sample_ch.valid && sample_ch.ready)
                expected_drive_q.push_back(
                    predict_drive({sample_ch.accel_y, sample_ch.accel_z}));
        end
    end

    // Result monitor: compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        drive_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_drive_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no sample outstanding: tilt %0d",
                             result_ch.tilt_angle);
            end
            else
            begin
                want = expected_drive_q.pop_front();
                check_field("drive_reverse", want.reverse, result_ch.drive_reverse);
                check_field("drive_magnitude", want.magnitude, result_ch.drive_magnitude);
                check_field("tilt_angle", want.tilt, result_ch.tilt_angle);
                check_field("settled", want.settled, result_ch.settled);
                check_field("beyond_open_limit", want.beyond, result_ch.beyond_open_limit);
            end
        end
    end

    // Run limit.
    initial
    begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus: directed samples under the reset settings, then phases of
    // register settings each followed by random samples.
    initial
    begin
        target_set = longint'(tps_pkg::TARGET_ANGLE_RESET);
        prop_set = longint'(tps_pkg::PROP_GAIN_RESET);
        integ_set = longint'(tps_pkg::INTEG_GAIN_RESET);
        period_set = longint'(tps_pkg::PERIOD_SECONDS_RESET);
        error_sum = 0;
        settled_seen = 1'b0;
        mismatches = 0;
        burst_left = 1;
        gap_left = 0;
        rx_style = RX_FREE;
        rx_window = 0;
        rx_phase = 0;
        hold_cnt = 0;
        hold_req = 1'b0;
        clk = 1'b0;
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.accel_y = '0;
        sample_ch.accel_z = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Extreme corners and the open-limit edge, before anything settles.
        queue_sample(-32768, -32768);
        queue_sample(32767, 32767);
        queue_sample(-32768, 32767);
        queue_sample(32767, -32768);
        queue_sample(1000, 838);
        queue_sample(1000, 839);
        queue_sample(1000, 840);
        queue_sample(1000, -839);
        queue_sample(0, 32767);
        queue_sample(0, -32768);
        // Negative x on the zero y axis gives plus pi.
        queue_sample(32767, 0);
        queue_sample(1, 0);
        // Either side of the settle band.
        queue_sample(-10000, 701);
        queue_sample(-10000, 700);
        queue_sample(-10000, -700);
        // Both axes zero, then the unit neighbours and two full-scale points.
        queue_sample(0, 0);
        queue_sample(-32768, 0);
        queue_sample(-1, 0);
        queue_sample(0, 1);
        queue_sample(0, -1);
        queue_sample(1, 1);
        queue_sample(1, -1);
        queue_sample(-1, 1);
        queue_sample(-1, -1);
        queue_sample(32767, 1);
        queue_random(60);
        wait_idle();

        // Top of every gain and the period register, target at plus pi, with a long result stall.
        write_all(16'sd25736, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_random(60);
        hold_req = 1'b1;
        wait_idle();

        // Gains and period at zero, target at minus pi: the PI sum is zero; a spare index is ignored.
        write_all(-16'sd25736, 16'h0000, 16'h0000, 16'h0000);
        write_reg(REG_FIRST_SPARE, 16'h1234);
        queue_random(40);
        wait_idle();

        // Targets outside the angle range.
        write_all(16'sh7FFF, 16'd256, 16'd512, 16'hFFFF);
        write_reg(REG_LAST_SPARE, 16'hFFFF);
        queue_random(60);
        wait_idle();
        write_all(16'sh8000, 16'd1, 16'hFFFF, 16'd1);
        queue_random(60);
        hold_req = 1'b1;
        wait_idle();

        // Random settings.
        repeat (5)
        begin
            write_all(CFG_DATA_W'($urandom()),
                      CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom()
                                                              : $urandom_range(0, 2048)),
                      CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom()
                                                              : $urandom_range(0, 64)),
                      CFG_DATA_W'($urandom()));
            if ($urandom_range(0, 1))
                write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_SPARE, REG_LAST_SPARE)),
                          CFG_DATA_W'($urandom()));
            queue_random(50);
            if ($urandom_range(0, 2) == 0)
                hold_req = 1'b1;
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_drive_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
